// ===== hw/rtl/ami_pkg.sv =====
// Shared types, constants and index helpers for the affine matrix inverse block.
`default_nettype none

package ami_pkg;

  localparam int unsigned FRAC_BITS_DEF = 16;
  localparam int unsigned ELEM_W        = 32;
  localparam int unsigned CF_W          = 64;
  localparam int unsigned DET_W         = 97;
  localparam int unsigned MUL_W         = 33;
  localparam int unsigned PROD_W        = 66;

  typedef struct packed {
    logic signed [ELEM_W-1:0] elem_x;
    logic signed [ELEM_W-1:0] elem_y;
    logic signed [ELEM_W-1:0] elem_z;
  } ami_req_t;

  typedef struct packed {
    logic signed [ELEM_W-1:0] res_x;
    logic signed [ELEM_W-1:0] res_y;
    logic signed [ELEM_W-1:0] res_z;
    logic                     last_row;
    logic                     singular;
  } ami_rsp_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_STORE,
    OP_CF_MUL,
    OP_DET_MUL,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_DIV_DONE,
    OP_TR_MUL,
    OP_TR_DONE,
    OP_EMIT
  } ami_op_t;

  typedef struct packed {
    ami_op_t    op;
    logic [3:0] idx;
    logic [1:0] part;
  } ami_cmd_t;

  typedef struct packed {
    logic out_free;
  } ami_stat_t;

  // Next index modulo three.
  function automatic logic [1:0] inc3(input logic [1:0] v);
    logic [1:0] r;
    case (v)
      2'd0:    r = 2'd1;
      2'd1:    r = 2'd2;
      default: r = 2'd0;
    endcase
    return r;
  endfunction

  // Row of a flat 3x3 index.
  function automatic logic [1:0] row_of(input logic [3:0] idx);
    logic [1:0] r;
    case (idx) inside
      4'd0, 4'd1, 4'd2: r = 2'd0;
      4'd3, 4'd4, 4'd5: r = 2'd1;
      default:          r = 2'd2;
    endcase
    return r;
  endfunction

  // Column of a flat 3x3 index.
  function automatic logic [1:0] col_of(input logic [3:0] idx);
    logic [1:0] r;
    case (idx) inside
      4'd0, 4'd3, 4'd6: r = 2'd0;
      4'd1, 4'd4, 4'd7: r = 2'd1;
      default:          r = 2'd2;
    endcase
    return r;
  endfunction

  // Flat index of row r, column c.
  function automatic logic [3:0] idx_of(input logic [1:0] r, input logic [1:0] c);
    return {2'b00, r} + {1'b0, r, 1'b0} + {2'b00, c};
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/ami_ctrl.sv =====
// Sequencer that steps the datapath through storing, cofactors, determinant, divisions, translation and output rows.
`default_nettype none

module ami_ctrl (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  req_valid,
  output logic                 req_ready,
  output ami_pkg::ami_cmd_t    cmd,
  input  ami_pkg::ami_stat_t   stat
);
  import ami_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_CF, S_DET, S_DETF, S_DIVI, S_DIVS, S_DIVF, S_GAP, S_EMIT, S_TR, S_TRF
  } state_t;

  localparam logic [5:0] CF_LAST  = 6'd17;
  localparam logic [5:0] DET_LAST = 6'd5;
  localparam logic [5:0] DIV_LAST = 6'd32;

  state_t     state;
  logic [5:0] cnt;
  logic [1:0] row_count;
  logic [1:0] irow;
  logic [1:0] icol;
  logic       last_flag;

  assign req_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      row_count <= '0;
      irow      <= '0;
      icol      <= '0;
      last_flag <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (req_valid) begin
            row_count <= row_count + 2'd1;
            if (row_count == 2'd3) begin
              state <= S_CF;
              cnt   <= '0;
            end
          end
        end
        S_CF: begin
          if (cnt == CF_LAST) begin
            state <= S_DET;
            cnt   <= '0;
          end else begin
            cnt <= cnt + 6'd1;
          end
        end
        S_DET: begin
          if (cnt == DET_LAST) begin
            state <= S_DETF;
          end else begin
            cnt <= cnt + 6'd1;
          end
        end
        S_DETF: begin
          state     <= S_DIVI;
          irow      <= '0;
          icol      <= '0;
          last_flag <= 1'b0;
        end
        S_DIVI: begin
          state <= S_DIVS;
          cnt   <= '0;
        end
        S_DIVS: begin
          if (cnt == DIV_LAST) begin
            state <= S_DIVF;
          end else begin
            cnt <= cnt + 6'd1;
          end
        end
        S_DIVF: begin
          if (icol == 2'd2) begin
            state <= S_GAP;
            icol  <= '0;
          end else begin
            icol  <= icol + 2'd1;
            state <= S_DIVI;
          end
        end
        S_GAP: begin
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (stat.out_free) begin
            if (last_flag) begin
              state <= S_IDLE;
            end else if (irow == 2'd2) begin
              state <= S_TR;
              irow  <= '0;
              icol  <= '0;
              cnt   <= '0;
            end else begin
              irow  <= irow + 2'd1;
              state <= S_DIVI;
            end
          end
        end
        S_TR: begin
          if (cnt == 6'd2) begin
            state <= S_TRF;
          end else begin
            cnt <= cnt + 6'd1;
          end
        end
        S_TRF: begin
          if (icol == 2'd2) begin
            state     <= S_GAP;
            last_flag <= 1'b1;
          end else begin
            icol  <= icol + 2'd1;
            cnt   <= '0;
            state <= S_TR;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    cmd.op   = OP_NONE;
    cmd.idx  = '0;
    cmd.part = '0;
    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd.op  = OP_STORE;
          cmd.idx = {2'b00, row_count};
        end
      end
      S_CF: begin
        cmd.op   = OP_CF_MUL;
        cmd.idx  = cnt[4:1];
        cmd.part = {1'b0, cnt[0]};
      end
      S_DET: begin
        cmd.op   = OP_DET_MUL;
        cmd.idx  = {2'b00, cnt[2:1]};
        cmd.part = {1'b0, cnt[0]};
      end
      S_DIVI: begin
        cmd.op  = OP_DIV_INIT;
        cmd.idx = idx_of(irow, icol);
      end
      S_DIVS: begin
        cmd.op   = OP_DIV_STEP;
        cmd.part = {1'b0, (cnt == 6'd0)};
      end
      S_DIVF: begin
        cmd.op  = OP_DIV_DONE;
        cmd.idx = idx_of(irow, icol);
      end
      S_EMIT: begin
        if (stat.out_free) begin
          cmd.op   = OP_EMIT;
          cmd.part = {1'b0, last_flag};
        end
      end
      S_TR: begin
        cmd.op   = OP_TR_MUL;
        cmd.idx  = {2'b00, icol};
        cmd.part = cnt[1:0];
      end
      S_TRF: begin
        cmd.op  = OP_TR_DONE;
        cmd.idx = {2'b00, icol};
      end
      default: ;
    endcase
  end

`ifndef NO_ASSERTIONS
  a_busy_rows: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> (row_count == 2'd0))
    else $error("row count not cleared while a matrix is in progress");
  a_cf_start: assert property (@(posedge clk) disable iff (rst)
    (state == S_CF && cnt == 6'd0) |-> ($past(state) == S_IDLE && $past(row_count) == 2'd3))
    else $error("cofactor pass started without a fourth row");
  a_div_len: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIVF) |-> ($past(state) == S_DIVS && $past(cnt) == DIV_LAST))
    else $error("division finished after the wrong number of steps");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/ami_dp.sv =====
// Datapath: row store, shared multiplier, accumulator, radix-2 divider and output register.
`default_nettype none

module ami_dp #(
  parameter int unsigned FRAC_BITS = ami_pkg::FRAC_BITS_DEF
) (
  input  wire                  clk,
  input  wire                  rst,
  input  ami_pkg::ami_req_t    req,
  input  ami_pkg::ami_cmd_t    cmd,
  output ami_pkg::ami_stat_t   stat,
  output logic                 rsp_valid,
  input  wire                  rsp_ready,
  output ami_pkg::ami_rsp_t    rsp
);
  import ami_pkg::*;

  localparam int unsigned DIV_W  = (2*FRAC_BITS + 66 > 130) ? 2*FRAC_BITS + 66 : 130;
  localparam int unsigned NUM_SH = 2*FRAC_BITS + 1;

  logic signed [ELEM_W-1:0] store [3][4];
  logic signed [CF_W-1:0]   cof [9];
  logic signed [ELEM_W-1:0] inv [9];
  logic signed [ELEM_W-1:0] out_row [3];
  logic signed [PROD_W-1:0] prod;
  logic signed [DET_W-1:0]  acc;
  logic [DIV_W-1:0]         num;
  logic [DIV_W-1:0]         dsh;
  logic [ELEM_W-1:0]        quo;
  logic                     ovf;
  logic                     q_neg;
  logic                     sing;
  ami_cmd_t                 cmd_q;

  // Operand selection for the shared multiplier.
  logic [1:0]               i_r, j_c, i1, i2, j1, j2;
  logic [1:0]               col_a, col_b, row_a, row_b;
  logic [1:0]               rsel [3];
  logic signed [ELEM_W-1:0] cval [3];
  logic [3:0]               cof_addr;
  logic signed [CF_W-1:0]   cof_rd;
  logic signed [MUL_W-1:0]  opa, opb;

  always_comb begin
    i_r   = row_of(cmd.idx);
    j_c   = col_of(cmd.idx);
    i1    = inc3(i_r);
    i2    = inc3(i1);
    j1    = inc3(j_c);
    j2    = inc3(j1);
    col_a = i1;
    col_b = i2;
    row_a = cmd.part[0] ? j2 : j1;
    row_b = cmd.part[0] ? j1 : j2;
    case (cmd.op)
      OP_DET_MUL: begin
        col_a = cmd.idx[1:0];
        row_a = 2'd0;
      end
      OP_TR_MUL: begin
        col_a = cmd.part;
        row_a = 2'd3;
      end
      default: ;
    endcase
    for (int c = 0; c < 3; c++) begin
      rsel[c] = (2'(c) == col_a) ? row_a : row_b;
      cval[c] = store[c][rsel[c]];
    end
    cof_addr = (cmd.op == OP_DET_MUL) ? idx_of(cmd.idx[1:0], 2'd0) : cmd.idx;
    cof_rd   = cof[cof_addr];
    opa      = {cval[col_a][ELEM_W-1], cval[col_a]};
    case (cmd.op)
      OP_DET_MUL: opb = cmd.part[0] ? {cof_rd[CF_W-1], cof_rd[CF_W-1:32]}
                                    : {1'b0, cof_rd[31:0]};
      OP_TR_MUL: begin
        opb = {inv[idx_of(cmd.part, cmd.idx[1:0])][ELEM_W-1],
               inv[idx_of(cmd.part, cmd.idx[1:0])]};
      end
      default:    opb = {cval[col_b][ELEM_W-1], cval[col_b]};
    endcase
  end

  // Divider setup and step values.
  logic [CF_W-1:0]   cmag;
  logic [DET_W-1:0]  dmag;
  logic              ge;
  logic [ELEM_W:0]   lim;
  logic [ELEM_W:0]   qm;
  logic [ELEM_W-1:0] div_val;

  always_comb begin
    cmag    = cof_rd[CF_W-1] ? CF_W'(-cof_rd) : CF_W'(cof_rd);
    dmag    = acc[DET_W-1] ? DET_W'(-acc) : DET_W'(acc);
    ge      = (num >= dsh);
    lim     = q_neg ? 33'd2147483648 : 33'd2147483647;
    qm      = (ovf || ({1'b0, quo} > lim)) ? lim : {1'b0, quo};
    div_val = q_neg ? ELEM_W'(-qm) : qm[ELEM_W-1:0];
  end

  // Translation result: negate the sum, round half away from zero, saturate.
  logic              t_neg;
  logic [DET_W-1:0]  t_mag;
  logic [DET_W-1:0]  t_rnd;
  logic [DET_W-1:0]  t_lim;
  logic [DET_W-1:0]  t_m;
  logic [ELEM_W-1:0] tr_val;

  always_comb begin
    t_neg  = !acc[DET_W-1] && (acc != '0);
    t_mag  = acc[DET_W-1] ? DET_W'(-acc) : DET_W'(acc);
    t_rnd  = (t_mag + (DET_W'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
    t_lim  = t_neg ? DET_W'(33'd2147483648) : DET_W'(33'd2147483647);
    t_m    = (t_rnd > t_lim) ? t_lim : t_rnd;
    tr_val = t_neg ? ELEM_W'(-t_m) : t_m[ELEM_W-1:0];
  end

  assign stat.out_free = !rsp_valid || rsp_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_q.op   <= OP_NONE;
      cmd_q.idx  <= '0;
      cmd_q.part <= '0;
      rsp_valid  <= 1'b0;
    end else begin
      cmd_q <= cmd;
      if (cmd.op == OP_EMIT) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    // Stage one: store, multiply, divide, emit.
    prod <= opa * opb;
    case (cmd.op)
      OP_STORE: begin
        store[0][cmd.idx[1:0]] <= req.elem_x;
        store[1][cmd.idx[1:0]] <= req.elem_y;
        store[2][cmd.idx[1:0]] <= req.elem_z;
      end
      OP_DIV_INIT: begin
        num   <= (DIV_W'(cmag) << NUM_SH) + DIV_W'(dmag);
        dsh   <= DIV_W'(dmag) << 33;
        q_neg <= cof_rd[CF_W-1] ^ acc[DET_W-1];
        sing  <= (acc == '0);
        quo   <= '0;
        ovf   <= 1'b0;
      end
      OP_DIV_STEP: begin
        if (cmd.part[0]) begin
          ovf <= ge;
        end else begin
          quo <= {quo[ELEM_W-2:0], ge};
          if (ge) begin
            num <= num - dsh;
          end
        end
        dsh <= dsh >> 1;
      end
      OP_DIV_DONE: begin
        inv[cmd.idx]             <= div_val;
        out_row[col_of(cmd.idx)] <= div_val;
      end
      OP_EMIT: begin
        rsp.res_x    <= sing ? '0 : out_row[0];
        rsp.res_y    <= sing ? '0 : out_row[1];
        rsp.res_z    <= sing ? '0 : out_row[2];
        rsp.last_row <= cmd.part[0];
        rsp.singular <= sing;
      end
      default: ;
    endcase
    // Stage two: accumulate the registered product and write cofactors and translation results.
    case (cmd_q.op)
      OP_CF_MUL: begin
        if (!cmd_q.part[0]) begin
          acc <= DET_W'(prod);
        end else begin
          cof[cmd_q.idx] <= acc[CF_W-1:0] - prod[CF_W-1:0];
        end
      end
      OP_DET_MUL: begin
        acc <= ((cmd_q.idx == 4'd0 && !cmd_q.part[0]) ? '0 : acc)
             + (cmd_q.part[0] ? (DET_W'(prod) <<< 32) : DET_W'(prod));
      end
      OP_TR_MUL: begin
        acc <= ((cmd_q.part == 2'd0) ? '0 : acc) + DET_W'(prod);
      end
      OP_TR_DONE: begin
        out_row[cmd_q.idx[1:0]] <= tr_val;
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

// ===== hw/rtl/affine_matrix_inverse.sv =====
// Top level of the 4x3 affine matrix inverse: sequencer plus datapath.
//
//   Channel | Signals                          | Payload
//   --------+----------------------------------+---------------------------------------
//   req     | req_valid, req_ready, req        | elem_x, elem_y, elem_z (one row)
//   rsp     | rsp_valid, rsp_ready, rsp        | res_x, res_y, res_z, last_row, singular
//
// A request row is taken while the block is idle; the first three rows only fill the row
// store. After the fourth row the block is busy until it emits the last result row, and
// output stalls lengthen that. Most of that time goes to the radix-2 divider: setup, 33
// steps and write-back for each of the nine inverse entries. Before it come the cofactor
// and determinant products and a settle step; the translation row follows the divided
// rows, and each of the four result rows gets a gap and an emit step. Reset clears the
// sequencer and the output valid; the row store holds no reset value. A stalled output
// row holds the sequencer until it is taken, and the next matrix's first request may be
// taken while the last result row still waits.
`default_nettype none

module affine_matrix_inverse #(
  parameter int unsigned FRAC_BITS = ami_pkg::FRAC_BITS_DEF
) (
  input  wire                clk,
  input  wire                rst,
  input  wire                req_valid,
  output logic               req_ready,
  input  ami_pkg::ami_req_t  req,
  output logic               rsp_valid,
  input  wire                rsp_ready,
  output ami_pkg::ami_rsp_t  rsp
);
  import ami_pkg::*;

  // Commands flow from the sequencer to the datapath; the datapath reports whether
  // its output register can take a new row.
  ami_cmd_t  cmd;
  ami_stat_t stat;

  ami_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  ami_dp #(
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cmd       (cmd),
    .stat      (stat),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

endmodule

`default_nettype wire
